// ===== design/dgdw_pkg.sv =====
// Shared types, constants and helpers for the date gap and deadline weight block.
package dgdw_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned IMP_W    = 8;
  localparam int unsigned COUNT_W  = 22;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned YY_W     = 15;
  localparam int unsigned DN_W     = 23;
  localparam int unsigned MD_W     = 9;
  localparam int unsigned Q_W      = 15;
  localparam int unsigned DIV_STEPS_DEF = Q_W;
  localparam logic [Q_W-1:0]     WEIGHT_NUM = 15'd25600;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'd4194303;
  localparam logic [YY_W-1:0]    YEAR_SHIFT = 15'd400;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR  = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [IMP_W-1:0]   importance;
    logic               bad;
    logic [Q_W-1:0]     divisor;
    logic [Q_W-1:0]     rem;
    logic [Q_W-1:0]     quot;
  } div_beat_t;

  // floor(y/100) for y below 16784
  function automatic logic [7:0] div100(input logic [YY_W-1:0] y);
    logic [YY_W+13-1:0] p;
    p = y * 13'd5243;
    return p[26:19];
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [7:0]      q;
    logic [YY_W-1:0] r;
    q = div100({1'b0, y});
    r = {1'b0, y} - YY_W'(q) * 15'd100;
    return (y[1:0] == 2'b00 && r != '0) || (r == '0 && q[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd2:                                       return leap ? 5'd29 : 5'd28;
      default:                                    return 5'd0;
    endcase
  endfunction

  // days before the month on a March-based year
  function automatic logic [MD_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    case (m)
      4'd3:    return 9'd0;
      4'd4:    return 9'd31;
      4'd5:    return 9'd61;
      4'd6:    return 9'd92;
      4'd7:    return 9'd122;
      4'd8:    return 9'd153;
      4'd9:    return 9'd184;
      4'd10:   return 9'd214;
      4'd11:   return 9'd245;
      4'd12:   return 9'd275;
      4'd1:    return 9'd306;
      4'd2:    return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

endpackage

// ===== design/dgdw_if.sv =====
// Channel interfaces for the date pair input and the result output.
interface dgdw_in_if
  import dgdw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  start_year;
  logic [MONTH_W-1:0] start_month;
  logic [DAY_W-1:0]   start_day;
  logic [YEAR_W-1:0]  end_year;
  logic [MONTH_W-1:0] end_month;
  logic [DAY_W-1:0]   end_day;
  logic [IMP_W-1:0]   importance;
  modport source (output valid, start_year, start_month, start_day, end_year, end_month,
                  end_day, importance, input ready);
  modport sink (input valid, start_year, start_month, start_day, end_year, end_month,
                end_day, importance, output ready);
endinterface

interface dgdw_out_if
  import dgdw_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  day_count;
  logic [WEIGHT_W-1:0] weight_q8;
  logic                bad_date;
  modport source (output valid, day_count, weight_q8, bad_date, input ready);
  modport sink (input valid, day_count, weight_q8, bad_date, output ready);
endinterface

// ===== design/dgdw_div_cell.sv =====
// One restoring-division cell: settles one quotient bit of 25600/count.
module dgdw_div_cell
  import dgdw_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      valid_in,
  input  div_beat_t beat_in,
  output logic      valid_out,
  output div_beat_t beat_out
);

  logic      valid_r;
  div_beat_t beat_r, beat_nxt;
  logic [Q_W:0] sh;

  always_comb begin
    beat_nxt = beat_in;
    sh = {beat_in.rem, WEIGHT_NUM[Q_W-1-STEP]};
    if (sh >= {1'b0, beat_in.divisor}) begin
      beat_nxt.rem  = Q_W'(sh - {1'b0, beat_in.divisor});
      beat_nxt.quot = {beat_in.quot[Q_W-2:0], 1'b1};
    end else begin
      beat_nxt.rem  = sh[Q_W-1:0];
      beat_nxt.quot = {beat_in.quot[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign valid_out = valid_r;
  assign beat_out  = beat_r;

endmodule

// ===== design/date_gap_and_deadline_weight.sv =====
// Top level: day count between two Gregorian dates and 9.8 deadline weight.
// Takes one date pair per clock while the pipeline advances, returns one result per
// pair, in order: the input stages form and subtract the day numbers, a chain of
// 15 division cells settles one bit each of 25600/count, and one output register
// holds the beat. The whole pipeline advances whenever the output register is empty
// or being taken, so throughput is one beat per cycle while the sink keeps up.
module date_gap_and_deadline_weight
  import dgdw_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  dgdw_in_if.sink    in_ch,
  dgdw_out_if.source out_ch
);

  localparam int unsigned DIV_STEPS = DIV_STEPS_DEF;

  logic en;
  logic out_valid_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [WEIGHT_W-1:0] out_weight_r;
  logic                out_bad_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: validity, shifted years, month offsets
  logic s1_valid_r;
  logic s1_bad_r, s1_bad_nxt;
  logic [YY_W-1:0] s1_ya_r, s1_ya_nxt, s1_yb_r, s1_yb_nxt;
  logic [MD_W-1:0] s1_ma_r, s1_ma_nxt, s1_mb_r, s1_mb_nxt;
  logic [IMP_W-1:0] s1_imp_r;
  logic ok_a, ok_b;

  always_comb begin
    ok_a = in_ch.start_month != '0 && in_ch.start_month <= MONTH_DEC &&
           in_ch.start_day != '0 &&
           in_ch.start_day <= month_len(in_ch.start_month, is_leap(in_ch.start_year));
    ok_b = in_ch.end_month != '0 && in_ch.end_month <= MONTH_DEC &&
           in_ch.end_day != '0 &&
           in_ch.end_day <= month_len(in_ch.end_month, is_leap(in_ch.end_year));
    s1_bad_nxt = !(ok_a && ok_b);
    s1_ya_nxt = {1'b0, in_ch.start_year} + YEAR_SHIFT
              - YY_W'(in_ch.start_month < MONTH_MAR);
    s1_yb_nxt = {1'b0, in_ch.end_year} + YEAR_SHIFT
              - YY_W'(in_ch.end_month < MONTH_MAR);
    s1_ma_nxt = month_offset(in_ch.start_month) + MD_W'(in_ch.start_day);
    s1_mb_nxt = month_offset(in_ch.end_month) + MD_W'(in_ch.end_day);
  end

  // stage 2: day numbers
  logic s2_valid_r, s2_bad_r;
  logic [DN_W-1:0] s2_a_r, s2_a_nxt, s2_b_r, s2_b_nxt;
  logic [IMP_W-1:0] s2_imp_r;
  logic [7:0] qa, qb;

  always_comb begin
    qa = div100(s1_ya_r);
    qb = div100(s1_yb_r);
    s2_a_nxt = DN_W'(s1_ya_r) * 23'd365 + DN_W'(s1_ya_r >> 2) - DN_W'(qa)
             + DN_W'(qa >> 2) + DN_W'(s1_ma_r);
    s2_b_nxt = DN_W'(s1_yb_r) * 23'd365 + DN_W'(s1_yb_r >> 2) - DN_W'(qb)
             + DN_W'(qb >> 2) + DN_W'(s1_mb_r);
  end

  // stage 3: difference, saturate, divisor clamp
  logic s3_valid_r;
  div_beat_t s3_r, s3_nxt;
  logic [DN_W-1:0] diff;

  always_comb begin
    diff = (s2_b_r > s2_a_r) ? s2_b_r - s2_a_r : '0;
    s3_nxt.bad        = s2_bad_r;
    s3_nxt.importance = s2_imp_r;
    if (s2_bad_r) begin
      s3_nxt.count = '0;
    end else if (diff > DN_W'(COUNT_MAX)) begin
      s3_nxt.count = COUNT_MAX;
    end else begin
      s3_nxt.count = diff[COUNT_W-1:0];
    end
    s3_nxt.divisor = (s3_nxt.count[COUNT_W-1:Q_W] != '0) ? '1 : s3_nxt.count[Q_W-1:0];
    s3_nxt.rem  = '0;
    s3_nxt.quot = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bad_r <= s1_bad_nxt;
      s1_ya_r  <= s1_ya_nxt;
      s1_yb_r  <= s1_yb_nxt;
      s1_ma_r  <= s1_ma_nxt;
      s1_mb_r  <= s1_mb_nxt;
      s1_imp_r <= in_ch.importance;
      s2_bad_r <= s1_bad_r;
      s2_a_r   <= s2_a_nxt;
      s2_b_r   <= s2_b_nxt;
      s2_imp_r <= s1_imp_r;
      s3_r     <= s3_nxt;
    end
  end

  // divider chain
  logic      cv [DIV_STEPS+1];
  div_beat_t cb [DIV_STEPS+1];

  assign cv[0] = s3_valid_r;
  assign cb[0] = s3_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    dgdw_div_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (cv[i]),
      .beat_in  (cb[i]),
      .valid_out(cv[i+1]),
      .beat_out (cb[i+1])
    );
  end

  // output register
  div_beat_t fin;
  logic [WEIGHT_W-1:0] weight_nxt;

  always_comb begin
    fin = cb[DIV_STEPS];
    if (fin.bad) begin
      weight_nxt = '0;
    end else if (fin.count == '0) begin
      weight_nxt = {1'b0, fin.importance, 8'd0};
    end else begin
      weight_nxt = {1'b0, fin.importance, 8'd0} + WEIGHT_W'(fin.quot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_count_r  <= fin.count;
      out_weight_r <= weight_nxt;
      out_bad_r    <= fin.bad;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.day_count = out_count_r;
  assign out_ch.weight_q8 = out_weight_r;
  assign out_ch.bad_date  = out_bad_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_count_r == '0 && out_weight_r == '0)
    else $error("bad date with nonzero result");

  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bad_r && out_count_r == '0 |-> out_weight_r[7:0] == '0)
    else $error("fraction bits set with zero count");

  a_large_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bad_r && out_count_r > COUNT_W'(WEIGHT_NUM)
    |-> out_weight_r[7:0] == '0)
    else $error("nonzero quotient for count above numerator");

endmodule
